// ===== rtl/core/nrsqrt_pkg.sv =====
package nrsqrt_pkg;

  // field and register widths
  localparam int X_W     = 24;   // x, unsigned Q2.22
  localparam int ROOT_W  = 23;   // root, unsigned Q1.22
  localparam int STEP_W  = 12;
  localparam int GUESS_W = 32;   // guess, signed Q12.20
  localparam int GUESS_IN_W = 24;
  localparam int THR_W   = 22;
  localparam int CFG_W   = 24;
  localparam int IDX_W   = 2;

  // datapath widths
  localparam int MUL_W  = 32;            // shared multiplier operand width
  localparam int PROD_W = 2 * MUL_W;
  localparam int G2_W   = 42;            // |g|^2 >> 20
  localparam int G3_W   = 53;            // g2*|g| >> 20
  localparam int XG3_W  = 55;            // g3*x >> 22
  localparam int P_W    = 46;            // g2*x >> 20
  localparam int ACC_W  = 77;            // widest full product (g3*x)
  localparam int DIFF_W = 57;            // 3g - xg3
  localparam int RMAG_W = 35;            // x*|g| >> 20
  localparam int G_FRAC = 20;
  localparam int X_FRAC = 22;

  // register indexes
  localparam logic [IDX_W-1:0] REG_GUESS  = 2'd0;
  localparam logic [IDX_W-1:0] REG_THRESH = 2'd1;
  localparam logic [IDX_W-1:0] REG_LIMIT  = 2'd2;

  localparam logic [CFG_W-1:0] GUESS_RST  = 24'd1048576;
  localparam logic [THR_W-1:0] THRESH_RST = 22'd42;
  localparam logic [STEP_W-1:0] LIMIT_RST = 12'd1024;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_G2,
    MUL_P_LO,
    MUL_P_HI,
    MUL_G3_LO,
    MUL_G3_HI,
    MUL_XG3_LO,
    MUL_XG3_HI,
    MUL_ROOT
  } mul_op_t;

  typedef enum logic [2:0] {
    SAVE_NONE,
    SAVE_G2,
    SAVE_ERR,
    SAVE_G3,
    SAVE_GUESS,
    SAVE_ROOT
  } save_op_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_SET,
    ACC_ADD_HI
  } acc_mode_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_G2_MUL, ST_G2_WAIT, ST_G2_SAVE,
    ST_P_LO, ST_P_HI, ST_P_WAIT, ST_P_SAVE,
    ST_CHECK,
    ST_G3_LO, ST_G3_HI, ST_G3_WAIT, ST_G3_SAVE,
    ST_X_LO, ST_X_HI, ST_X_WAIT, ST_X_SAVE,
    ST_R_MUL, ST_R_WAIT, ST_R_SAVE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic     load;
    mul_op_t  mul_op;
    save_op_t save_op;
  } cmd_t;

  typedef struct packed {
    logic err_ok;
    logic limit_hit;
  } stat_t;

  typedef struct packed {
    logic [CFG_W-1:0]  guess;
    logic [THR_W-1:0]  thresh;
    logic [STEP_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic              converged;
    logic [STEP_W-1:0] steps;
    logic              last;
  } result_t;

endpackage

// ===== rtl/core/newton_inverse_sqrt_root_top.sv =====
// Square root by Newton iteration on the inverse root, fixed point.
// Input stream (s_axis): one word per value, x in unsigned Q2.22, tlast
// passed through to the matching result. Output stream (m_axis): one word
// per input word, in order: root in Q1.22, step count, and tuser = converged
// (0 when the iteration limit stopped the loop).
// Configuration: cfg_we/cfg_index/cfg_data write initial guess (Q4.20),
// error threshold (Q0.22) and iteration limit; write only while idle.
// One value is worked on at a time on a single shared 32x32 multiplier;
// the products with g2 or g3 as an operand are built from two partial products.
// From accept to result valid the block runs the initial error test, then
// for each Newton step taken a new guess and a fresh error test, then the
// root and the hand-over to the output register.
// A new word can be accepted in the cycle after the previous result is loaded
// into the output register, so no word is taken while one is being worked on.
// The output register holds a result while m_axis_tready is low; the next
// value is then worked on in full and waits in its final state until the
// register frees up.
// Reset (rst, synchronous) returns the controller to idle, drops the output
// word and restores guess 1.0, threshold 42 and limit 1024.
module newton_inverse_sqrt_root_top (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] x_value
  input  logic        s_axis_tlast,   // last_in
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [22:0] root_value, [34:23] step_count, rest zero
  output logic        m_axis_tuser,   // converged
  output logic        m_axis_tlast    // last_out
);
  import nrsqrt_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  stat_t   stat;
  result_t result;
  result_t out_word;
  logic    out_valid;
  logic    done;
  logic    out_free;

  // config registers; an index past the list is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.guess  <= GUESS_RST;
      cfg.thresh <= THRESH_RST;
      cfg.limit  <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GUESS:  cfg.guess  <= cfg_data;
        REG_THRESH: cfg.thresh <= cfg_data[THR_W-1:0];
        REG_LIMIT:  cfg.limit  <= cfg_data[STEP_W-1:0];
        default:    ;
      endcase
    end
  end

  assign out_free = !out_valid || m_axis_tready;

  nrsqrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .out_free (out_free),
    .stat     (stat),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .done     (done)
  );

  nrsqrt_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .cfg     (cfg),
    .x_in    (s_axis_tdata),
    .last_in (s_axis_tlast),
    .stat    (stat),
    .result  (result)
  );

  // output register: loaded on done, cleared once the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_word <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_word.steps, out_word.root};
  assign m_axis_tuser  = out_word.converged;
  assign m_axis_tlast  = out_word.last;

endmodule

// ===== rtl/core/nrsqrt_ctrl.sv =====
module nrsqrt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_free,
  input  nrsqrt_pkg::stat_t   stat,
  output logic                in_ready,
  output nrsqrt_pkg::cmd_t    cmd,
  output logic                done
);
  import nrsqrt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    done        = 1'b0;
    cmd.load    = 1'b0;
    cmd.mul_op  = MUL_NONE;
    cmd.save_op = SAVE_NONE;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_G2_MUL;
        end
      end
      // g2 = g*g
      ST_G2_MUL: begin
        cmd.mul_op = MUL_G2;
        state_next = ST_G2_WAIT;
      end
      ST_G2_WAIT: state_next = ST_G2_SAVE;
      ST_G2_SAVE: begin
        cmd.save_op = SAVE_G2;
        state_next  = ST_P_LO;
      end
      // p = g2*x, then error test
      ST_P_LO: begin
        cmd.mul_op = MUL_P_LO;
        state_next = ST_P_HI;
      end
      ST_P_HI: begin
        cmd.mul_op = MUL_P_HI;
        state_next = ST_P_WAIT;
      end
      ST_P_WAIT: state_next = ST_P_SAVE;
      ST_P_SAVE: begin
        cmd.save_op = SAVE_ERR;
        state_next  = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.err_ok || stat.limit_hit) begin
          state_next = ST_R_MUL;
        end else begin
          state_next = ST_G3_LO;
        end
      end
      // g3 = g2*g
      ST_G3_LO: begin
        cmd.mul_op = MUL_G3_LO;
        state_next = ST_G3_HI;
      end
      ST_G3_HI: begin
        cmd.mul_op = MUL_G3_HI;
        state_next = ST_G3_WAIT;
      end
      ST_G3_WAIT: state_next = ST_G3_SAVE;
      ST_G3_SAVE: begin
        cmd.save_op = SAVE_G3;
        state_next  = ST_X_LO;
      end
      // xg3 = g3*x, then new guess
      ST_X_LO: begin
        cmd.mul_op = MUL_XG3_LO;
        state_next = ST_X_HI;
      end
      ST_X_HI: begin
        cmd.mul_op = MUL_XG3_HI;
        state_next = ST_X_WAIT;
      end
      ST_X_WAIT: state_next = ST_X_SAVE;
      ST_X_SAVE: begin
        cmd.save_op = SAVE_GUESS;
        state_next  = ST_G2_MUL;
      end
      // root = x*g
      ST_R_MUL: begin
        cmd.mul_op = MUL_ROOT;
        state_next = ST_R_WAIT;
      end
      ST_R_WAIT: state_next = ST_R_SAVE;
      ST_R_SAVE: begin
        cmd.save_op = SAVE_ROOT;
        state_next  = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          done       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/nrsqrt_dp.sv =====
module nrsqrt_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  nrsqrt_pkg::cmd_t              cmd,
  input  nrsqrt_pkg::cfg_t              cfg,
  input  logic [nrsqrt_pkg::X_W-1:0]    x_in,
  input  logic                          last_in,
  output nrsqrt_pkg::stat_t             stat,
  output nrsqrt_pkg::result_t           result
);
  import nrsqrt_pkg::*;

  localparam logic signed [DIFF_W-1:0] GMAX =
    DIFF_W'((64'd1 << (GUESS_W - 1)) - 64'd1);
  localparam logic [P_W-1:0] ONE_Q22 = P_W'(64'd1 << X_FRAC);
  localparam logic [ROOT_W-1:0] ROOT_MAX = '1;

  logic [X_W-1:0]          x;
  logic                    last;
  logic signed [GUESS_W-1:0] g;
  logic [G2_W-1:0]         g2;
  logic [G3_W-1:0]         g3;
  logic [STEP_W-1:0]       steps;
  logic                    err_ok;
  logic [ROOT_W-1:0]       root;

  logic [PROD_W-1:0]       prod;
  acc_mode_t               acc_mode;
  logic [ACC_W-1:0]        acc;

  logic [MUL_W-1:0]        mul_a, mul_b;
  acc_mode_t               mode_issue;
  logic [GUESS_W-1:0]      g_mag;

  logic [P_W-1:0]          p, err;
  logic [XG3_W-1:0]        xg3_mag;
  logic signed [DIFF_W-1:0] g_ext, tri_g, xg3_s, diff, half;
  logic signed [GUESS_W-1:0] g_new;
  logic [RMAG_W-1:0]       root_mag;
  logic [ROOT_W-1:0]       root_new;

  assign g_mag = g[GUESS_W-1] ? (~g + GUESS_W'(1)) : g;

  // operand select for the shared 32x32 multiplier
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    mode_issue = ACC_SET;
    unique case (cmd.mul_op)
      MUL_NONE:   mode_issue = ACC_HOLD;
      MUL_G2:     begin mul_a = g_mag; mul_b = g_mag; end
      MUL_P_LO:   begin mul_a = g2[MUL_W-1:0]; mul_b = MUL_W'(x); end
      MUL_P_HI: begin
        mul_a      = MUL_W'(g2[G2_W-1:MUL_W]);
        mul_b      = MUL_W'(x);
        mode_issue = ACC_ADD_HI;
      end
      MUL_G3_LO:  begin mul_a = g2[MUL_W-1:0]; mul_b = g_mag; end
      MUL_G3_HI: begin
        mul_a      = MUL_W'(g2[G2_W-1:MUL_W]);
        mul_b      = g_mag;
        mode_issue = ACC_ADD_HI;
      end
      MUL_XG3_LO: begin mul_a = g3[MUL_W-1:0]; mul_b = MUL_W'(x); end
      MUL_XG3_HI: begin
        mul_a      = MUL_W'(g3[G3_W-1:MUL_W]);
        mul_b      = MUL_W'(x);
        mode_issue = ACC_ADD_HI;
      end
      MUL_ROOT:   begin mul_a = MUL_W'(x); mul_b = g_mag; end
      default:    mode_issue = ACC_HOLD;
    endcase
  end

  // error |g2*x - 1| in Q.22
  assign p   = acc[P_W+G_FRAC-1:G_FRAC];
  assign err = (p >= ONE_Q22) ? (p - ONE_Q22) : (ONE_Q22 - p);

  // next guess (3g - xg3)/2, halved toward zero, saturated
  assign xg3_mag = acc[XG3_W+X_FRAC-1:X_FRAC];
  assign g_ext   = DIFF_W'(g);
  assign tri_g   = g_ext + (g_ext <<< 1);
  assign xg3_s   = g[GUESS_W-1] ? -$signed({2'b00, xg3_mag}) : $signed({2'b00, xg3_mag});
  assign diff    = tri_g - xg3_s;
  assign half    = (diff + $signed(DIFF_W'(diff[DIFF_W-1]))) >>> 1;

  always_comb begin
    if (half > GMAX) begin
      g_new = GUESS_W'(GMAX);
    end else if (half < -GMAX) begin
      g_new = GUESS_W'(-GMAX);
    end else begin
      g_new = half[GUESS_W-1:0];
    end
  end

  // root x*g, negative clamps to zero, large saturates
  assign root_mag = acc[RMAG_W+G_FRAC-1:G_FRAC];
  always_comb begin
    if (g[GUESS_W-1]) begin
      root_new = '0;
    end else if (|root_mag[RMAG_W-1:ROOT_W]) begin
      root_new = ROOT_MAX;
    end else begin
      root_new = root_mag[ROOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_mode <= ACC_HOLD;
    end else begin
      acc_mode <= mode_issue;
    end
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    unique case (acc_mode)
      ACC_SET:    acc <= ACC_W'(prod);
      ACC_ADD_HI: acc <= acc + (ACC_W'(prod) << MUL_W);
      default:    acc <= acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x     <= x_in;
      last  <= last_in;
      g     <= GUESS_W'(cfg.guess);
      steps <= '0;
    end
    unique case (cmd.save_op)
      SAVE_G2:    g2 <= acc[G2_W+G_FRAC-1:G_FRAC];
      SAVE_ERR:   err_ok <= (err <= P_W'(cfg.thresh));
      SAVE_G3:    g3 <= acc[G3_W+G_FRAC-1:G_FRAC];
      SAVE_GUESS: begin
        g     <= g_new;
        steps <= steps + STEP_W'(1);
      end
      SAVE_ROOT:  root <= root_new;
      default:    ;
    endcase
  end

  assign stat.err_ok    = err_ok;
  assign stat.limit_hit = (steps >= cfg.limit);

  assign result.root      = root;
  assign result.converged = err_ok;
  assign result.steps     = steps;
  assign result.last      = last;

endmodule

// ===== test/tb_newton_inverse_sqrt_root_top.sv =====
module tb_newton_inverse_sqrt_root_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nrsqrt_pkg::*;

  // the unused fourth register slot; a write there must change nothing
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

  localparam logic [23:0] HALF_G   = 24'd524288;     // 0.5 in Q4.20
  localparam logic [23:0] X_ONE    = 24'd4194304;    // 1.0 in Q2.22
  localparam logic [23:0] X_TOP    = 24'd12582912;   // 3.0, top of the clean random x range
  localparam logic [22:0] ROOT_SAT = 23'h7FFFFF;

  // fixed-point limits of the datapath
  localparam longint FX_CAP   = 64'h4000_0000_0000_0000;        // 2^62
  localparam longint G_MAX    = (longint'(1) << (GUESS_W - 1)) - 1;
  localparam longint ONE_Q22  = longint'(1) << X_FRAC;
  localparam longint ROOT_TOP = (longint'(1) << ROOT_W) - 1;

  localparam int PHASES    = 6;
  localparam int PHASE_LEN = 240;
  localparam int PROBES    = 20;

  // one directed word: register setting, stimulus, and the result where it
  // can be stated outright (typed = 1); other rows go to the predictor
  typedef struct packed {
    logic [23:0]       guess;
    logic [THR_W-1:0]  thresh;
    logic [STEP_W-1:0] limit;
    logic [23:0]       x;
    logic              last;
    logic              typed;
    result_t           want;
  } probe_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_GUESS;
  logic [23:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;     // [23:0] x_value
  logic        s_axis_tlast = 1'b0;   // last_in
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;          // [22:0] root_value, [34:23] step_count, rest zero
  logic        m_axis_tuser;          // converged
  logic        m_axis_tlast;          // last_out

  // testbench copy of the register file
  logic [23:0]       cfg_guess  = GUESS_RST;
  logic [THR_W-1:0]  cfg_thresh = THRESH_RST;
  logic [STEP_W-1:0] cfg_limit  = LIMIT_RST;

  result_t pending_roots[$];
  int      mismatches = 0;
  int      words_seen = 0;
  int      words_converged = 0;
  int      settings_used = 1;
  bit      src_calm = 1'b0;
  bit      sink_calm = 1'b0;
  longint  cycles = 0;
  longint  cycle_budget = 20000;     // grows with every word sent

  always #6 clk = ~clk;

  newton_inverse_sqrt_root_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // (a*b) >> sh on magnitudes, truncated, capped at 2^62, sign put back
  function automatic longint fx_mul(input longint a, input longint b, input int sh);
    bit [127:0] ma, mb, prod;
    ma = (a < 0) ? 128'(-a) : 128'(a);
    mb = (b < 0) ? 128'(-b) : 128'(b);
    prod = (ma * mb) >> sh;
    if (prod > 128'(FX_CAP)) prod = 128'(FX_CAP);
    return ((a < 0) != (b < 0)) ? -$signed(prod[63:0]) : $signed(prod[63:0]);
  endfunction

  // |g*g*x - 1| in Q.22
  function automatic longint fx_err(input longint g, input longint x);
    longint d;
    d = fx_mul(fx_mul(g, g, G_FRAC), x, G_FRAC) - ONE_Q22;
    return (d < 0) ? -d : d;
  endfunction

  function automatic result_t predict_root(input logic [23:0] x_in, input logic last_in);
    longint  g, x, thr, err, nx, root;
    int      steps;
    result_t r;
    x = longint'(x_in);
    g = longint'(cfg_guess);
    thr = longint'(cfg_thresh);
    if (g > G_MAX) g = G_MAX;
    steps = 0;
    err = fx_err(g, x);
    while (err > thr && steps < int'(cfg_limit)) begin
      // g' = (3g - x*g^3) / 2, halved toward zero
      nx = (3 * g - fx_mul(fx_mul(fx_mul(g, g, G_FRAC), g, G_FRAC), x, X_FRAC)) / 2;
      if (nx > G_MAX) nx = G_MAX;
      if (nx < -G_MAX) nx = -G_MAX;
      g = nx;
      steps++;
      err = fx_err(g, x);
    end
    root = fx_mul(x, g, G_FRAC);
    if (root < 0) root = 0;
    if (root > ROOT_TOP) root = ROOT_TOP;
    r.root = root[ROOT_W-1:0];
    r.converged = (err <= thr);
    r.steps = steps[STEP_W-1:0];
    r.last = last_in;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Directed words
  // ---------------------------------------------------------------------

  function automatic probe_t probe_row(input int n);
    case (n)
      // reset setting: exact root, slow small x, top of range and zero
      // input both run into the step limit with the guess stuck or growing
      0:  return '{GUESS_RST, 22'd42, 12'd1024, X_ONE, 1'b0, 1'b1,
                   '{23'd4194304, 1'b1, 12'd0, 1'b0}};
      1:  return '{GUESS_RST, 22'd42, 12'd1024, 24'd1048576, 1'b0, 1'b0, '0};
      2:  return '{GUESS_RST, 22'd42, 12'd1024, 24'd1, 1'b0, 1'b0, '0};
      3:  return '{GUESS_RST, 22'd42, 12'd1024, X_TOP, 1'b0, 1'b1,
                   '{23'd0, 1'b0, 12'd1024, 1'b0}};
      4:  return '{GUESS_RST, 22'd42, 12'd1024, 24'd0, 1'b1, 1'b1,
                   '{23'd0, 1'b0, 12'd1024, 1'b1}};
      // no steps allowed: error test on the guess alone, root saturation
      5:  return '{GUESS_RST, 22'd42, 12'd0, X_ONE, 1'b0, 1'b1,
                   '{23'd4194304, 1'b1, 12'd0, 1'b0}};
      6:  return '{GUESS_RST, 22'd42, 12'd0, 24'd8388608, 1'b0, 1'b1,
                   '{ROOT_SAT, 1'b0, 12'd0, 1'b0}};
      7:  return '{GUESS_RST, 22'd42, 12'd0, 24'hFFFFFF, 1'b1, 1'b1,
                   '{ROOT_SAT, 1'b0, 12'd0, 1'b1}};
      // half guess lets x above 3.0 converge; roots near 2.0 saturate
      8:  return '{HALF_G, 22'd42, 12'd64, 24'hFFFFFF, 1'b0, 1'b0, '0};
      9:  return '{HALF_G, 22'd42, 12'd64, 24'd14680064, 1'b0, 1'b0, '0};
      10: return '{HALF_G, 22'd42, 12'd64, X_TOP, 1'b1, 1'b0, '0};
      // smallest guess: g*g truncates to zero and the guess stays put
      11: return '{24'd1, 22'd42, 12'd64, X_ONE, 1'b0, 1'b0, '0};
      12: return '{24'd1, 22'd42, 12'd64, 24'd1, 1'b0, 1'b0, '0};
      // largest guess: fine for tiny x, diverges for x = 1.0
      13: return '{24'hFFFFFF, 22'd42, 12'd64, 24'd1, 1'b0, 1'b0, '0};
      14: return '{24'hFFFFFF, 22'd42, 12'd64, X_ONE, 1'b1, 1'b0, '0};
      // zero threshold
      15: return '{GUESS_RST, 22'd0, 12'd8, X_ONE, 1'b0, 1'b1,
                   '{23'd4194304, 1'b1, 12'd0, 1'b0}};
      16: return '{GUESS_RST, 22'd0, 12'd8, 24'd3145728, 1'b1, 1'b0, '0};
      // widest threshold with the longest loop
      17: return '{GUESS_RST, 22'h3FFFFF, 12'd4095, 24'd0, 1'b0, 1'b1,
                   '{23'd0, 1'b0, 12'd4095, 1'b0}};
      18: return '{GUESS_RST, 22'h3FFFFF, 12'd4095, 24'd8388607, 1'b0, 1'b1,
                   '{23'd8388607, 1'b1, 12'd0, 1'b0}};
      19: return '{GUESS_RST, 22'h3FFFFF, 12'd4095, 24'd6291456, 1'b1, 1'b1,
                   '{23'd6291456, 1'b1, 12'd0, 1'b1}};
      default: return '0;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Handshake helpers
  // ---------------------------------------------------------------------

  // mostly back to back, now and then a long hole
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 24);
    return $urandom_range(60, 300);
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("[%0t] %s mismatch: got %0d, want %0d", $realtime, what, got, want);
  endtask

  // one input word; the expectation is queued when it is taken
  task automatic send_x(input logic [23:0] x, input logic last, input logic typed,
                        input result_t want);
    int gap;
    gap = src_calm ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    s_axis_tlast  <= last;
    cycle_budget += 4 * (13 + 16 * longint'(cfg_limit)) + 2500;
    do @(posedge clk); while (!s_axis_tready);
    pending_roots.push_back(typed ? want : predict_root(x, last));
  endtask

  // hold the sender off until every queued result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_roots.size() != 0);
  endtask

  // all three registers, written only with the block idle; spare upper
  // bits of the data bus carry junk that the block must drop
  task automatic program_regs(input logic [23:0] g, input logic [THR_W-1:0] t,
                              input logic [STEP_W-1:0] l);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= REG_GUESS;
    cfg_data  <= g;
    @(posedge clk);
    cfg_index <= REG_THRESH;
    cfg_data  <= {2'($urandom), t};
    @(posedge clk);
    cfg_index <= REG_LIMIT;
    cfg_data  <= {12'($urandom), l};
    @(posedge clk);
    cfg_we     <= 1'b0;
    cfg_guess  = g;
    cfg_thresh = t;
    cfg_limit  = l;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------
  // Result side: random back-pressure and the scoreboard
  // ---------------------------------------------------------------------

  int stall_left = 0;

  always @(posedge clk) begin : sink_pace
    int n;
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (sink_calm) begin
      m_axis_tready <= 1'b1;
    end else begin
      n = pick_gap();
      m_axis_tready <= (n == 0);
      if (n != 0) stall_left = n - 1;
    end
  end

  always @(posedge clk) begin : check_roots
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      words_seen++;
      if (m_axis_tuser) words_converged++;
      if (pending_roots.size() == 0) begin
        flag_mismatch("unexpected word", longint'(m_axis_tdata), longint'(0));
      end else begin
        want = pending_roots.pop_front();
        if (m_axis_tdata[22:0] != want.root)
          flag_mismatch("root", longint'(m_axis_tdata[22:0]), longint'(want.root));
        if (m_axis_tuser != want.converged)
          flag_mismatch("converged", longint'(m_axis_tuser), longint'(want.converged));
        if (m_axis_tdata[34:23] != want.steps)
          flag_mismatch("step count", longint'(m_axis_tdata[34:23]), longint'(want.steps));
        if (m_axis_tlast != want.last)
          flag_mismatch("tlast", longint'(m_axis_tlast), longint'(want.last));
        if (m_axis_tdata[39:35] != '0)
          flag_mismatch("tdata padding", longint'(m_axis_tdata[39:35]), longint'(0));
      end
    end
  end

  // watchdog: budget is topped up per word from the current step limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > cycle_budget) begin
      $display("timed out after %0d cycles, %0d results outstanding",
               cycles, pending_roots.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  initial begin
    probe_t            p;
    logic [23:0]       g, x;
    logic [THR_W-1:0]  t;
    logic [STEP_W-1:0] l;
    bit [127:0]        xcap;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // stray write to the unused slot; the reset setting must survive it
    cfg_we    <= 1'b1;
    cfg_index <= REG_SPARE;
    cfg_data  <= 24'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;

    // directed words; the registers are rewritten only when a row asks
    // for a different setting
    for (int i = 0; i < PROBES; i++) begin
      p = probe_row(i);
      if (p.guess != cfg_guess || p.thresh != cfg_thresh || p.limit != cfg_limit)
        program_regs(p.guess, p.thresh, p.limit);
      send_x(p.x, p.last, p.typed, p.want);
    end

    // random phases: the first one back at the reset setting with clean
    // words only (its step limit is long), the rest at random settings
    // with short limits and some rough words mixed in
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        program_regs(GUESS_RST, THRESH_RST, LIMIT_RST);
      end else begin
        case ($urandom_range(0, 3))
          0:       g = GUESS_RST;
          1:       g = 24'($urandom_range(1 << 18, 1 << 21));
          2:       g = 24'($urandom_range(1, 24'hFFFFFF));
          default: g = HALF_G;
        endcase
        case ($urandom_range(0, 3))
          0:       t = THRESH_RST;
          1:       t = THR_W'($urandom_range(0, 63));
          2:       t = THR_W'($urandom_range(0, 22'h3FFFFF));
          default: t = THR_W'($urandom_range(64, 4095));
        endcase
        l = ($urandom_range(0, 3) == 0) ? STEP_W'($urandom_range(0, 3))
                                         : STEP_W'($urandom_range(4, 48));
        program_regs(g, t, l);
      end
      src_calm  = (ph % 3 == 1);
      sink_calm = (ph % 3 == 2);

      // keep x*g^2 under about 2.9 so Newton converges from the guess
      xcap = (128'd12163481 << 40) / (128'(cfg_guess) * 128'(cfg_guess));
      if (xcap > 128'(X_TOP)) xcap = 128'(X_TOP);

      for (int i = 0; i < PHASE_LEN; i++) begin
        if (ph == 2 && i == PHASE_LEN / 2) drain_results();
        if (ph != 0 && $urandom_range(0, 99) < 12) begin
          case ($urandom_range(0, 2))
            0:       x = '0;
            1:       x = 24'($urandom);
            default: x = 24'($urandom_range(int'(X_TOP) + 1, 24'hFFFFFF));
          endcase
        end else begin
          x = 24'($urandom_range(1, int'(xcap)));
          // a quarter pushed down towards tiny x for long climbs
          if ($urandom_range(0, 3) == 0) x = x >> $urandom_range(1, 22);
          if (x == '0) x = 24'd1;
        end
        send_x(x, (i == PHASE_LEN - 1) || ($urandom_range(0, 7) == 0), 1'b0, '0);
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (pending_roots.size() != 0)
      flag_mismatch("results outstanding", longint'(pending_roots.size()), longint'(0));

    $display("%0d roots checked over %0d register settings, %0d converged, %0d hit the step limit",
             words_seen, settings_used, words_converged, words_seen - words_converged);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/nrsqrt_pkg.sv
rtl/core/nrsqrt_ctrl.sv
rtl/core/nrsqrt_dp.sv
rtl/core/newton_inverse_sqrt_root_top.sv
test/tb_newton_inverse_sqrt_root_top.sv
